// ----- rtl/core/dhbc_pkg.sv -----
// Shared field widths, register indexes and reset values of the Hall boxcar conditioner.
package dhbc_pkg;

  localparam int SAMPLE_W    = 12;
  localparam int POS_W       = 13;
  localparam int DELTA_W     = 14;
  localparam int OFFSET_W    = 12;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 12;

  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_A = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_B = 8'd1;

  localparam logic [OFFSET_W-1:0] OFFSET_A_RESET = 12'd3160;
  localparam logic [OFFSET_W-1:0] OFFSET_B_RESET = 12'd3000;

endpackage

// ----- rtl/core/dhbc_sample_if.sv -----
// Sample channel carrying one raw ADC sample of each Hall sensor.
interface dhbc_sample_if import dhbc_pkg::*;;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_a;
  logic [SAMPLE_W-1:0] sample_b;

  modport source (output valid, output sample_a, output sample_b, input ready);
  modport sink (input valid, input sample_a, input sample_b, output ready);
endinterface

// ----- rtl/core/dhbc_result_if.sv -----
// Result channel carrying the positions and position changes of both sensors.
interface dhbc_result_if import dhbc_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [POS_W-1:0]   position_a;
  logic signed [POS_W-1:0]   position_b;
  logic signed [DELTA_W-1:0] delta_a;
  logic signed [DELTA_W-1:0] delta_b;

  modport source (output valid, output position_a, output position_b,
                  output delta_a, output delta_b, input ready);
  modport sink (input valid, input position_a, input position_b,
                input delta_a, input delta_b, output ready);
endinterface

// ----- rtl/core/dhbc_cfg_if.sv -----
// Configuration write channel carrying a register index and write data.
interface dhbc_cfg_if import dhbc_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/dual_hall_boxcar_conditioner.sv -----
// Top level of the dual Hall-sensor boxcar conditioner.
// Samples pass the window stage, sum, product and result registers before results are valid.
// Throughput: one sample pair per cycle; the pipeline stalls as a whole while a result waits.
// The window memory takes one read and one write per cycle, to different entries.
// Reset: offsets return to 3160 and 3000; sums, pointer and previous positions clear at once.
// Window entries not yet written read as zero, so no clearing pass follows reset.
module dual_hall_boxcar_conditioner import dhbc_pkg::*; #(
  parameter int WINDOW_DEPTH = 256,
  parameter int SAMPLE_BITS  = 12
) (
  input  logic          clk,
  input  logic          rst,
  dhbc_sample_if.sink   samples,
  dhbc_result_if.source results,
  dhbc_cfg_if.sink      cfg
);

  localparam int SumW = SAMPLE_BITS + $clog2(WINDOW_DEPTH);

  logic                en;
  logic                take;
  logic                sum_valid;
  logic [SumW-1:0]     sum_a;
  logic [SumW-1:0]     sum_b;
  logic [OFFSET_W-1:0] offset_a;
  logic [OFFSET_W-1:0] offset_b;
  logic [POS_W-1:0]    position_a;
  logic [POS_W-1:0]    position_b;
  logic [DELTA_W-1:0]  delta_a;
  logic [DELTA_W-1:0]  delta_b;

  assign en            = !results.valid || results.ready;
  assign samples.ready = en;
  assign take          = samples.valid && en;
  assign cfg.ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_a <= OFFSET_A_RESET;
      offset_b <= OFFSET_B_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_OFFSET_A: offset_a <= cfg.data[OFFSET_W-1:0];
        REG_OFFSET_B: offset_b <= cfg.data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  dhbc_window #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .take     (take),
    .sample_a (samples.sample_a),
    .sample_b (samples.sample_b),
    .sum_valid(sum_valid),
    .sum_a    (sum_a),
    .sum_b    (sum_b)
  );

  dhbc_scale #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .sum_valid (sum_valid),
    .sum_a     (sum_a),
    .sum_b     (sum_b),
    .offset_a  (offset_a),
    .offset_b  (offset_b),
    .out_valid (results.valid),
    .position_a(position_a),
    .position_b(position_b),
    .delta_a   (delta_a),
    .delta_b   (delta_b)
  );

  assign results.position_a = position_a;
  assign results.position_b = position_b;
  assign results.delta_a    = delta_a;
  assign results.delta_b    = delta_b;

endmodule

// ----- rtl/core/dhbc_window.sv -----
// Window memory with read-modify-write update of the running sums of both channels.
module dhbc_window import dhbc_pkg::*; #(
  parameter int WINDOW_DEPTH = 256,
  parameter int SAMPLE_BITS  = 12,
  localparam int SumW = SAMPLE_BITS + $clog2(WINDOW_DEPTH)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                take,
  input  logic [SAMPLE_W-1:0] sample_a,
  input  logic [SAMPLE_W-1:0] sample_b,
  output logic                sum_valid,
  output logic [SumW-1:0]     sum_a,
  output logic [SumW-1:0]     sum_b
);

  localparam int AddrW = $clog2(WINDOW_DEPTH);
  localparam int ExtW  = (SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(WINDOW_DEPTH - 1);

  logic [2*SAMPLE_BITS-1:0] mem [WINDOW_DEPTH];
  logic [2*SAMPLE_BITS-1:0] rd_data;
  logic [AddrW-1:0]         ptr;
  logic [AddrW-1:0]         wr_addr;
  logic                     wrapped;
  logic                     old_valid;
  logic                     stage_valid;
  logic [ExtW-1:0]          ext_a;
  logic [ExtW-1:0]          ext_b;
  logic [SAMPLE_BITS-1:0]   new_a;
  logic [SAMPLE_BITS-1:0]   new_b;
  logic [SAMPLE_BITS-1:0]   wr_a;
  logic [SAMPLE_BITS-1:0]   wr_b;
  logic [SAMPLE_BITS-1:0]   old_a;
  logic [SAMPLE_BITS-1:0]   old_b;
  logic [SumW-1:0]          sum_a_next;
  logic [SumW-1:0]          sum_b_next;

  assign ext_a = ExtW'(sample_a);
  assign ext_b = ExtW'(sample_b);
  assign new_a = ext_a[SAMPLE_BITS-1:0];
  assign new_b = ext_b[SAMPLE_BITS-1:0];

  // Entries are written in pointer order, so an entry holds a sample only once the
  // pointer has wrapped; before that it reads as zero.
  assign old_a = old_valid ? rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS] : '0;
  assign old_b = old_valid ? rd_data[SAMPLE_BITS-1:0] : '0;

  assign sum_a_next = sum_a + SumW'(wr_a) - SumW'(old_a);
  assign sum_b_next = sum_b + SumW'(wr_b) - SumW'(old_b);

  always_ff @(posedge clk) begin
    if (take) begin
      rd_data <= mem[ptr];
    end
    if (en && stage_valid) begin
      mem[wr_addr] <= {wr_a, wr_b};
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      wr_addr   <= ptr;
      wr_a      <= new_a;
      wr_b      <= new_b;
      old_valid <= wrapped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr         <= '0;
      wrapped     <= 1'b0;
      stage_valid <= 1'b0;
      sum_valid   <= 1'b0;
      sum_a       <= '0;
      sum_b       <= '0;
    end else if (en) begin
      stage_valid <= take;
      sum_valid   <= stage_valid;
      if (take) begin
        if (ptr == LastAddr) begin
          ptr     <= '0;
          wrapped <= 1'b1;
        end else begin
          ptr <= ptr + 1'b1;
        end
      end
      if (stage_valid) begin
        sum_a <= sum_a_next;
        sum_b <= sum_b_next;
      end
    end
  end

endmodule

// ----- rtl/core/dhbc_scale.sv -----
// Mean by reciprocal multiplication, offset removal, position change and result register.
module dhbc_scale import dhbc_pkg::*; #(
  parameter int WINDOW_DEPTH = 256,
  parameter int SAMPLE_BITS  = 12,
  localparam int SumW = SAMPLE_BITS + $clog2(WINDOW_DEPTH)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      sum_valid,
  input  logic [SumW-1:0]           sum_a,
  input  logic [SumW-1:0]           sum_b,
  input  logic [OFFSET_W-1:0]       offset_a,
  input  logic [OFFSET_W-1:0]       offset_b,
  output logic                      out_valid,
  output logic [POS_W-1:0]          position_a,
  output logic [POS_W-1:0]          position_b,
  output logic [DELTA_W-1:0]        delta_a,
  output logic [DELTA_W-1:0]        delta_b
);

  localparam int MulW  = SumW + 1;
  localparam int Shift = SumW + $clog2(WINDOW_DEPTH);
  localparam longint unsigned RecipFull =
    ((64'd1 << Shift) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH);
  localparam logic [MulW-1:0] Recip = RecipFull[MulW-1:0];

  logic                      prod_valid;
  logic [SumW+MulW-1:0]      prod_a;
  logic [SumW+MulW-1:0]      prod_b;
  logic [SAMPLE_BITS-1:0]    mean_a;
  logic [SAMPLE_BITS-1:0]    mean_b;
  logic [DELTA_W-1:0]        pos_a;
  logic [DELTA_W-1:0]        pos_b;
  logic [DELTA_W-1:0]        last_a;
  logic [DELTA_W-1:0]        last_b;

  assign mean_a = prod_a[Shift +: SAMPLE_BITS];
  assign mean_b = prod_b[Shift +: SAMPLE_BITS];
  assign pos_a  = DELTA_W'(offset_a) - DELTA_W'(mean_a);
  assign pos_b  = DELTA_W'(mean_b) - DELTA_W'(offset_b);

  always_ff @(posedge clk) begin
    if (en && sum_valid) begin
      prod_a <= (SumW+MulW)'(sum_a) * (SumW+MulW)'(Recip);
      prod_b <= (SumW+MulW)'(sum_b) * (SumW+MulW)'(Recip);
    end
    if (en && prod_valid) begin
      position_a <= pos_a[POS_W-1:0];
      position_b <= pos_b[POS_W-1:0];
      delta_a    <= pos_a - last_a;
      delta_b    <= pos_b - last_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
      last_a     <= '0;
      last_b     <= '0;
    end else if (en) begin
      prod_valid <= sum_valid;
      out_valid  <= prod_valid;
      if (prod_valid) begin
        last_a <= pos_a;
        last_b <= pos_b;
      end
    end
  end

endmodule
